FILE: rtl/vntf_pkg.sv
// shared constants, types and helpers of the value noise texture factor block
`timescale 1ns / 1ps

package vntf_pkg;

  // noise octaves summed per transaction
  localparam int OCTAVES = 3;

  // field widths
  localparam int PW    = 32;
  localparam int AMPW  = 24;
  localparam int AMW   = AMPW - 1;
  localparam int SEEDW = 32;
  localparam int FACW  = 24;

  // lattice coordinate: index and fraction
  localparam int FRW   = 16;
  localparam int IDXW  = 32;
  localparam int CRW   = IDXW + FRW;

  // divider: numerator is |p| * 2^(16 + OCTAVES - 1)
  localparam int SH    = FRW + OCTAVES - 1;
  localparam int QW    = PW + SH;
  localparam int RW    = PW - 1;

  // hash
  localparam int HW = 32;
  localparam logic [HW-1:0] K_SEED = 32'd374761393;
  localparam logic [HW-1:0] K_I    = 32'd3266489917;
  localparam logic [HW-1:0] K_J    = 32'd2246822519;
  localparam logic [HW-1:0] K_K    = 32'd668265263;
  localparam logic [HW-1:0] K_MIX  = 32'd2654435761;
  localparam int SHR_A = 15;
  localparam int SHR_B = 13;

  // octave pipeline depth
  localparam int OCT_LAT = 7;

  // weighted octave sum and final scaling
  localparam int SW    = HW + OCTAVES;
  localparam int SPLIT = 18;
  localparam int PRW   = AMW + SW;
  localparam int TSH   = 31;
  localparam int TW    = PRW - TSH;
  localparam int DIVD  = (1 << OCTAVES) - 1;
  localparam int DIVK  = TW + OCTAVES;
  localparam int MW    = TW + 2;
  localparam logic [63:0] RECIP64 = ((64'd1 << DIVK) + 64'(DIVD) - 64'd1) / 64'(DIVD);
  localparam logic [MW-1:0] RECIP = RECIP64[MW-1:0];
  localparam int QDW   = AMW + 1;
  localparam int FW    = FACW + 2;
  localparam logic [FACW-1:0] ONE_Q16 = 24'h010000;
  localparam logic [FACW-1:0] FAC_MAX = 24'hFFFFFF;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [QW-1:0] nq;
    logic          neg;
  } div_t;

  typedef struct packed {
    logic             bypass;
    logic [AMW-1:0]   amp;
    logic [SEEDW-1:0] seed;
    logic [RW-1:0]    dvs;
  } side_t;

  typedef struct packed {
    logic           bypass;
    logic [AMW-1:0] amp;
  } tex_t;

  typedef struct packed {
    logic [IDXW-1:0] idx;
    logic [FRW-1:0]  frac;
  } coord_t;

  typedef struct packed {
    logic [FACW-1:0] factor;
    logic            sat;
  } res_t;

  // product modulo 2^32
  function automatic logic [HW-1:0] mul32(input logic [HW-1:0] a, input logic [HW-1:0] b);
    logic [HW-1:0] p;
    p = a * b;
    return p;
  endfunction

endpackage

FILE: rtl/vntf_div_step.sv
// one restoring division step for the three lattice axes
`timescale 1ns / 1ps

module vntf_div_step (
  input  logic                       clk,
  input  logic                       en,
  input  logic [vntf_pkg::RW-1:0]    dvs_i,
  input  vntf_pkg::div_t [2:0]       div_i,
  output vntf_pkg::div_t [2:0]       div_o
);

  vntf_pkg::div_t [2:0]         div_nxt;
  vntf_pkg::div_t [2:0]         div_r;
  logic [2:0][vntf_pkg::RW:0]   trial;
  logic [2:0][vntf_pkg::RW:0]   diff;
  logic [2:0]                   ge;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      trial[a] = {div_i[a].rem, div_i[a].nq[vntf_pkg::QW-1]};
      diff[a]  = trial[a] - {1'b0, dvs_i};
      ge[a]    = (trial[a] >= {1'b0, dvs_i});
      div_nxt[a].rem = ge[a] ? diff[a][vntf_pkg::RW-1:0] : trial[a][vntf_pkg::RW-1:0];
      div_nxt[a].nq  = {div_i[a].nq[vntf_pkg::QW-2:0], ge[a]};
      div_nxt[a].neg = div_i[a].neg;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r <= div_nxt;
    end
  end

  assign div_o = div_r;

endmodule

FILE: rtl/vntf_octave.sv
// one noise octave: corner hash, smoothstep and trilinear blend
`timescale 1ns / 1ps

module vntf_octave (
  input  logic                          clk,
  input  logic                          en,
  input  vntf_pkg::coord_t [2:0]        crd_i,
  input  logic [vntf_pkg::SEEDW-1:0]    seed_i,
  output logic [vntf_pkg::HW-1:0]       noise_o
);

  localparam int HW = vntf_pkg::HW;

  // a + floor((b - a) * s / 2^16)
  function automatic logic [HW-1:0] blend(input logic [HW-1:0] a, input logic [HW-1:0] b,
                                          input logic [15:0] s);
    logic signed [HW:0]     d;
    logic signed [HW+17:0]  p;
    logic signed [HW+17:0]  r;
    d = $signed({1'b0, b}) - $signed({1'b0, a});
    p = d * $signed({1'b0, s});
    r = $signed({18'b0, a}) + (p >>> 16);
    return r[HW-1:0];
  endfunction

  // stage 1: hash products and squared fractions
  logic [HW-1:0]        p_seed_r, p_i_r, p_j_r, p_k_r;
  logic [2:0][31:0]     ff_r;
  logic [2:0][15:0]     f1_r;
  // stage 2: corner sums and smoothstep
  logic [HW-1:0]        base;
  logic [7:0][HW-1:0]   h2_r;
  logic [2:0][15:0]     s2_r;
  logic [2:0][17:0]     wt;
  logic [2:0][49:0]     sp;
  // stages 3 and 4: mix
  logic [7:0][HW-1:0]   x3;
  logic [7:0][HW-1:0]   m3_r;
  logic [7:0][HW-1:0]   h4_r;
  logic [2:0][15:0]     s3_r, s4_r;
  // stages 5 to 7: blend along x, y, z
  logic [3:0][HW-1:0]   bx_r;
  logic [1:0][HW-1:0]   by_r;
  logic [15:0]          s5y_r, s5z_r, s6z_r;
  logic [HW-1:0]        noise_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_seed_r <= vntf_pkg::mul32(seed_i, vntf_pkg::K_SEED);
      p_i_r    <= vntf_pkg::mul32(crd_i[0].idx, vntf_pkg::K_I);
      p_j_r    <= vntf_pkg::mul32(crd_i[1].idx, vntf_pkg::K_J);
      p_k_r    <= vntf_pkg::mul32(crd_i[2].idx, vntf_pkg::K_K);
      for (int a = 0; a < 3; a++) begin
        ff_r[a] <= {16'b0, crd_i[a].frac} * {16'b0, crd_i[a].frac};
        f1_r[a] <= crd_i[a].frac;
      end
    end
  end

  always_comb begin
    base = p_seed_r + p_i_r + p_j_r + p_k_r;
    for (int a = 0; a < 3; a++) begin
      wt[a] = 18'd196608 - {1'b0, f1_r[a], 1'b0};
      sp[a] = {18'b0, ff_r[a]} * {32'b0, wt[a]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 8; c++) begin
        h2_r[c] <= base + (c[0] ? vntf_pkg::K_I : '0) + (c[1] ? vntf_pkg::K_J : '0)
                        + (c[2] ? vntf_pkg::K_K : '0);
      end
      for (int a = 0; a < 3; a++) begin
        s2_r[a] <= sp[a][47:32];
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 8; c++) begin
      x3[c] = h2_r[c] ^ (h2_r[c] >> vntf_pkg::SHR_A);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 8; c++) begin
        m3_r[c] <= vntf_pkg::mul32(x3[c], vntf_pkg::K_MIX);
        h4_r[c] <= m3_r[c] ^ (m3_r[c] >> vntf_pkg::SHR_B);
      end
      s3_r <= s2_r;
      s4_r <= s3_r;
      // corner index is dz*4 + dy*2 + dx
      for (int i = 0; i < 4; i++) begin
        bx_r[i] <= blend(h4_r[2*i], h4_r[2*i+1], s4_r[0]);
      end
      s5y_r <= s4_r[1];
      s5z_r <= s4_r[2];
      for (int i = 0; i < 2; i++) begin
        by_r[i] <= blend(bx_r[2*i], bx_r[2*i+1], s5y_r);
      end
      s6z_r   <= s5z_r;
      noise_r <= blend(by_r[0], by_r[1], s6z_r);
    end
  end

  assign noise_o = noise_r;

endmodule

FILE: rtl/vntf_combine.sv
// octave sum, contrast scaling and clamp of the factor
`timescale 1ns / 1ps

module vntf_combine (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        en,
  input  logic                                        valid_i,
  input  vntf_pkg::tex_t                              tex_i,
  input  logic [vntf_pkg::OCTAVES-1:0][vntf_pkg::HW-1:0] noise_i,
  output logic                                        valid_o,
  output vntf_pkg::res_t                              res_o
);

  localparam int SW    = vntf_pkg::SW;
  localparam int SPLIT = vntf_pkg::SPLIT;
  localparam int AMW   = vntf_pkg::AMW;
  localparam int PRW   = vntf_pkg::PRW;
  localparam int TW    = vntf_pkg::TW;
  localparam int MW    = vntf_pkg::MW;
  localparam int QDW   = vntf_pkg::QDW;
  localparam int FW    = vntf_pkg::FW;
  localparam int FACW  = vntf_pkg::FACW;

  logic [4:0]                v_r;
  logic [4:0]                v_nxt;
  vntf_pkg::tex_t            tex1_r, tex2_r, tex3_r, tex4_r;

  logic [SW-1:0]             acc;
  logic [SW-1:0]             s1_r;
  logic [AMW+SPLIT-1:0]      plo_r;
  logic [AMW+SW-SPLIT-1:0]   phi_r;
  logic [PRW-1:0]            prod;
  logic [TW-1:0]             t_r;
  logic [TW+MW-1:0]          rp;
  logic [QDW-1:0]            qd_r;
  logic signed [FW-1:0]      f;
  vntf_pkg::res_t            res_nxt;
  vntf_pkg::res_t            res_r;

  assign v_nxt = {v_r[3:0], valid_i};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= v_nxt;
    end
  end

  always_comb begin
    acc = '0;
    for (int o = 0; o < vntf_pkg::OCTAVES; o++) begin
      acc = acc + (SW'(noise_i[o]) << (vntf_pkg::OCTAVES - 1 - o));
    end
    prod = (PRW'(phi_r) << SPLIT) + PRW'(plo_r);
    rp   = (TW+MW)'(t_r) * (TW+MW)'(vntf_pkg::RECIP);
    // 1 - amp + amp * sum / (weight / 2)
    f    = $signed(FW'(vntf_pkg::ONE_Q16)) - $signed(FW'(tex4_r.amp)) + $signed(FW'(qd_r));
    if (tex4_r.bypass) begin
      res_nxt.factor = vntf_pkg::ONE_Q16;
      res_nxt.sat    = 1'b0;
    end else if (f[FW-1]) begin
      res_nxt.factor = '0;
      res_nxt.sat    = 1'b0;
    end else if (f > $signed(FW'(vntf_pkg::FAC_MAX))) begin
      res_nxt.factor = vntf_pkg::FAC_MAX;
      res_nxt.sat    = 1'b1;
    end else begin
      res_nxt.factor = f[FACW-1:0];
      res_nxt.sat    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r   <= acc;
      tex1_r <= tex_i;
      plo_r  <= (AMW+SPLIT)'(tex1_r.amp) * (AMW+SPLIT)'(s1_r[SPLIT-1:0]);
      phi_r  <= (AMW+SW-SPLIT)'(tex1_r.amp) * (AMW+SW-SPLIT)'(s1_r[SW-1:SPLIT]);
      tex2_r <= tex1_r;
      t_r    <= prod[PRW-1:vntf_pkg::TSH];
      tex3_r <= tex2_r;
      qd_r   <= rp[vntf_pkg::DIVK +: QDW];
      tex4_r <= tex3_r;
      res_r  <= res_nxt;
    end
  end

  assign valid_o = v_r[4];
  assign res_o   = res_r;

endmodule

FILE: rtl/value_noise_texture_factor_core.sv
// top level of the value noise texture factor block
`timescale 1ns / 1ps

// value noise texture factor: for each surface point transaction the block returns a
// reflectivity factor in unsigned Q8.16, built from three octaves of trilinear value
// noise scaled by the texture amplitude. a non-positive amplitude or scale gives exactly
// 1.0. the block is fully pipelined and takes one transaction per clock while in_stall is
// low. a transaction passes 65 register stages: one input register, 50 restoring divider
// steps (one quotient bit per step, the lattice coordinate is point * 2^18 / scale, shared
// by all octaves), one sign fixup stage, seven octave stages (hash multiplies, smoothstep,
// three blends), five combine stages and the output register. a one-entry skid buffer sits
// behind the output register, so in_stall rises in the cycle after a result arrives while
// the output register is stalled, and no transaction is lost or repeated.
module value_noise_texture_factor_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [31:0]          in_point_x,
  input  logic signed [31:0]          in_point_y,
  input  logic signed [31:0]          in_point_z,
  input  logic signed [23:0]          in_amplitude,
  input  logic signed [31:0]          in_scale,
  input  logic [31:0]                 in_seed,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [23:0]                 out_factor,
  output logic                        out_saturated
);

  localparam int QW  = vntf_pkg::QW;
  localparam int PW  = vntf_pkg::PW;
  localparam int OL  = vntf_pkg::OCT_LAT;
  localparam int OCT = vntf_pkg::OCTAVES;

  // whole pipeline moves while the skid buffer is empty
  logic adv;

  // input stage: magnitudes for the divider and side data
  logic [2:0][PW-1:0]       pt;
  logic [2:0][PW-1:0]       mag;
  vntf_pkg::div_t [2:0]     div_in;
  vntf_pkg::side_t          side_in;

  assign pt = {in_point_z, in_point_y, in_point_x};

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      mag[a] = pt[a][PW-1] ? (~pt[a] + PW'(1)) : pt[a];
      div_in[a].rem = '0;
      div_in[a].nq  = {mag[a], vntf_pkg::SH'(0)};
      div_in[a].neg = pt[a][PW-1];
    end
    // texture off when amplitude or scale is zero or negative
    side_in.bypass = in_amplitude[vntf_pkg::AMPW-1] || (in_amplitude == '0) ||
                     in_scale[PW-1] || (in_scale == '0);
    side_in.amp    = in_amplitude[vntf_pkg::AMW-1:0];
    side_in.seed   = in_seed;
    side_in.dvs    = in_scale[vntf_pkg::RW-1:0];
  end

  // divider pipeline, bit 0 / index 0 is the input register
  logic [QW:0]               v_div_r;
  logic [QW:0]               v_div_nxt;
  vntf_pkg::side_t           side_r [QW+1];
  vntf_pkg::div_t [2:0]      div0_r;
  vntf_pkg::div_t [2:0]      div_w [QW+1];

  assign v_div_nxt = {v_div_r[QW-1:0], in_valid};
  assign div_w[0]  = div0_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      div0_r    <= div_in;
      side_r[0] <= side_in;
    end
  end

  for (genvar g = 0; g < QW; g++) begin : g_div
    vntf_div_step u_step (
      .clk   (clk),
      .en    (adv),
      .dvs_i (side_r[g].dvs),
      .div_i (div_w[g]),
      .div_o (div_w[g+1])
    );

    always_ff @(posedge clk) begin
      if (adv) begin
        side_r[g+1] <= side_r[g];
      end
    end
  end

  // quotient sign fixup: floor for negative points
  logic                      vq_r;
  vntf_pkg::side_t           sq_r;
  logic [2:0][QW-1:0]        q_nxt;
  logic [2:0][QW-1:0]        q_r;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (!div_w[QW][a].neg) begin
        q_nxt[a] = div_w[QW][a].nq;
      end else if (div_w[QW][a].rem != '0) begin
        q_nxt[a] = ~div_w[QW][a].nq;
      end else begin
        q_nxt[a] = ~div_w[QW][a].nq + QW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q_r  <= q_nxt;
      sq_r <= side_r[QW];
    end
  end

  // octaves: octave o uses the coordinate shifted down by OCTAVES-1-o
  logic [OCT-1:0][vntf_pkg::HW-1:0] noise;

  for (genvar o = 0; o < OCT; o++) begin : g_oct
    vntf_pkg::coord_t [2:0]        crd;
    logic [vntf_pkg::CRW-1:0]      qs [3];
    logic [vntf_pkg::SEEDW-1:0]    sd;

    always_comb begin
      for (int a = 0; a < 3; a++) begin
        qs[a]         = q_r[a][OCT-1-o +: vntf_pkg::CRW];
        crd[a].idx    = qs[a][vntf_pkg::CRW-1:vntf_pkg::FRW];
        crd[a].frac   = qs[a][vntf_pkg::FRW-1:0];
      end
      sd = sq_r.seed + vntf_pkg::SEEDW'(o);
    end

    vntf_octave u_oct (
      .clk     (clk),
      .en      (adv),
      .crd_i   (crd),
      .seed_i  (sd),
      .noise_o (noise[o])
    );
  end

  // texture side data follows the octave pipeline
  logic [OL-1:0]             v_oct_r;
  logic [OL-1:0]             v_oct_nxt;
  vntf_pkg::tex_t            tex_r [OL];

  assign v_oct_nxt = {v_oct_r[OL-2:0], vq_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_div_r <= '0;
      vq_r    <= 1'b0;
      v_oct_r <= '0;
    end else if (adv) begin
      v_div_r <= v_div_nxt;
      vq_r    <= v_div_r[QW];
      v_oct_r <= v_oct_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tex_r[0].bypass <= sq_r.bypass;
      tex_r[0].amp    <= sq_r.amp;
      for (int i = 1; i < OL; i++) begin
        tex_r[i] <= tex_r[i-1];
      end
    end
  end

  // combine stages
  logic                      tail_v;
  vntf_pkg::res_t            tail_res;

  vntf_combine u_comb (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .valid_i (v_oct_r[OL-1]),
    .tex_i   (tex_r[OL-1]),
    .noise_i (noise),
    .valid_o (tail_v),
    .res_o   (tail_res)
  );

  // output register with skid buffer
  logic                      out_v_r, out_v_nxt;
  logic                      skid_v_r, skid_v_nxt;
  vntf_pkg::res_t            out_res_r, out_res_nxt;
  vntf_pkg::res_t            skid_res_r, skid_res_nxt;
  logic                      free;

  assign adv      = !skid_v_r;
  assign in_stall = skid_v_r;

  always_comb begin
    out_v_nxt    = out_v_r;
    skid_v_nxt   = skid_v_r;
    out_res_nxt  = out_res_r;
    skid_res_nxt = skid_res_r;
    free         = !out_v_r || !out_stall;
    if (skid_v_r) begin
      if (free) begin
        out_v_nxt   = 1'b1;
        out_res_nxt = skid_res_r;
        skid_v_nxt  = 1'b0;
      end
    end else if (tail_v) begin
      if (free) begin
        out_v_nxt   = 1'b1;
        out_res_nxt = tail_res;
      end else begin
        skid_v_nxt   = 1'b1;
        skid_res_nxt = tail_res;
      end
    end else if (free) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign out_valid     = out_v_r;
  assign out_factor    = out_res_r.factor;
  assign out_saturated = out_res_r.sat;

endmodule

FILE: test/tb_value_noise_texture_factor_core.sv
// testbench for the value noise texture factor core with its own noise predictor
`timescale 1ns / 1ps

module tb_value_noise_texture_factor_core;

  // one surface point transaction
  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [23:0] amp;
    logic signed [31:0] scl;
    logic [31:0]        seed;
  } texel_req_t;

  // one reflectivity result
  typedef struct {
    logic [23:0] factor;
    logic        sat;
  } refl_t;

  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 120;
  localparam int HOLD_CYCLES  = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_point_x = '0;
  logic signed [31:0] in_point_y = '0;
  logic signed [31:0] in_point_z = '0;
  logic signed [23:0] in_amplitude = '0;
  logic signed [31:0] in_scale = '0;
  logic [31:0] in_seed = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [23:0] out_factor;
  logic out_saturated;

  texel_req_t pending_q[$];
  refl_t      factor_q[$];
  int errors = 0;
  int accepted = 0;
  int cycles = 0;
  bit taken = 1'b0;
  bit hold_off = 1'b0;
  bit stim_done = 1'b0;

  value_noise_texture_factor_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_point_x(in_point_x), .in_point_y(in_point_y), .in_point_z(in_point_z),
    .in_amplitude(in_amplitude), .in_scale(in_scale), .in_seed(in_seed),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_factor(out_factor), .out_saturated(out_saturated)
  );

  always #2 clk = ~clk;

  // floor division, c division truncates toward zero
  function automatic longint floor_quot(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && ((n < 0) != (d < 0))) q = q - 1;
    return q;
  endfunction

  // multiply / xor-shift corner hash, value read as q0.32
  function automatic logic [31:0] lattice_hash(logic [31:0] i, logic [31:0] j,
                                               logic [31:0] k, logic [31:0] s);
    logic [31:0] h;
    h = s * vntf_pkg::K_SEED;
    h = h + i * vntf_pkg::K_I;
    h = h + j * vntf_pkg::K_J;
    h = h + k * vntf_pkg::K_K;
    h = h ^ (h >> vntf_pkg::SHR_A);
    h = h * vntf_pkg::K_MIX;
    h = h ^ (h >> vntf_pkg::SHR_B);
    return h;
  endfunction

  // smoothstep weight of a q0.16 fraction
  function automatic longint smooth_w(longint f);
    longint p;
    p = f * f * (3 * 65536 - 2 * f);
    return p >>> 32;
  endfunction

  function automatic longint lerp16(longint a, longint b, longint s);
    return (a * (65536 - s) + b * s) >>> 16;
  endfunction

  // trilinear value noise of one octave, q0.32
  function automatic longint octave_value(longint p[3], longint scl, int o, logic [31:0] s);
    logic [31:0] lat[3];
    longint w[3];
    longint q, yz[2], zz[2];
    logic [63:0] uq;
    for (int a = 0; a < 3; a++) begin
      q = floor_quot(p[a] * (longint'(1) << (o + 16)), scl);
      uq = q;
      lat[a] = uq[47:16];
      w[a] = smooth_w(longint'(uq[15:0]));
    end
    for (int dk = 0; dk < 2; dk++) begin
      for (int dj = 0; dj < 2; dj++) begin
        yz[dj] = lerp16(lattice_hash(lat[0], lat[1] + dj, lat[2] + dk, s),
                        lattice_hash(lat[0] + 1, lat[1] + dj, lat[2] + dk, s), w[0]);
      end
      zz[dk] = lerp16(yz[0], yz[1], w[1]);
    end
    return lerp16(zz[0], zz[1], w[2]);
  endfunction

  // reflectivity factor of one transaction
  function automatic refl_t predict_factor(texel_req_t t);
    refl_t r;
    longint p[3];
    longint sum, wt, f;
    p[0] = t.px;
    p[1] = t.py;
    p[2] = t.pz;
    r.sat = 1'b0;
    if (t.amp <= 0 || t.scl <= 0) begin
      r.factor = vntf_pkg::ONE_Q16;
      return r;
    end
    sum = 0;
    for (int o = 0; o < vntf_pkg::OCTAVES; o++)
      sum += octave_value(p, longint'(t.scl), o, t.seed + o) << (vntf_pkg::OCTAVES - 1 - o);
    wt = longint'((1 << vntf_pkg::OCTAVES) - 1) << 32;
    f = 65536 + floor_quot(longint'(t.amp) * (2 * sum - wt), wt);
    if (f < 0) begin
      f = 0;
    end else if (f > 64'hFFFFFF) begin
      f = 64'hFFFFFF;
      r.sat = 1'b1;
    end
    r.factor = f[23:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (errors < 30) $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    errors++;
  endtask

  task automatic add_req(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                         logic [23:0] a, logic [31:0] sc, logic [31:0] sd);
    texel_req_t t;
    t.px = x;
    t.py = y;
    t.pz = z;
    t.amp = a;
    t.scl = sc;
    t.seed = sd;
    pending_q.push_back(t);
  endtask

  function automatic logic [31:0] rand_point();
    case ($urandom_range(0, 2))
      0: return $urandom;
      1: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
      default: return $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_scale();
    case ($urandom_range(0, 3))
      0: return $urandom_range(1, 32'h7FFF_FFFF);
      1: return $urandom_range(1, 32'h0000_FFFF);
      default: return $urandom_range(32'h0000_4000, 32'h0040_0000);
    endcase
  endfunction

  // stimulus: directed corners, then random texels
  initial begin
    // texture disabled by amplitude or scale
    add_req(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 24'h0, 32'h0001_0000, 32'h1);
    add_req(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 24'h800000, 32'h0001_0000, 32'h1);
    add_req(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 24'h010000, 32'h0, 32'h1);
    add_req(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 24'h010000, 32'h8000_0000, 32'h1);
    add_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFFFFFF, 32'hFFFF_FFFF, 32'h0);
    // extremes of the point with smallest and largest scale, cell index wraps; then zero, negative and mixed points
    add_req(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 24'h7FFFFF, 32'h1, 32'hFFFF_FFFF);
    add_req(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 24'h7FFFFF, 32'h1, 32'hFFFF_FFFE);
    add_req(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 24'h000001, 32'h7FFF_FFFF, 32'h0);
    add_req(32'h0, 32'h0, 32'h0, 24'h7FFFFF, 32'h7FFF_FFFF, 32'h0);
    add_req(32'h0, 32'h0, 32'h0, 24'h000001, 32'h0001_0000, 32'h0);
    add_req(32'hFFFF_0000, 32'h0000_8000, 32'hFFFF_8000, 24'h7FFFFF, 32'h0001_0000, 32'h5);
    add_req(32'h1234_5678, 32'hEDCB_A987, 32'h0F0F_0F0F, 24'h400000, 32'h0000_0003, 32'hAAAA_5555);
    // high amplitude drives the factor negative and high
    for (int n = 0; n < 10; n++)
      add_req($urandom, $urandom, $urandom, 24'h7FFFFF, $urandom_range(1, 32'h0010_0000), $urandom);
    // random body
    for (int n = 0; n < 900; n++) begin
      if ($urandom_range(0, 99) < 10)
        add_req(rand_point(), rand_point(), rand_point(), $urandom, $urandom, $urandom);
      else
        add_req(rand_point(), rand_point(), rand_point(),
                $urandom_range(0, 1) ? $urandom_range(1, 24'h7FFFFF) : $urandom_range(1, 24'h02_0000),
                rand_scale(), $urandom);
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    wait (pending_q.size() == 0 && !in_valid);
    stim_done = 1'b1;
  end

  // long receiver hold-off while the sender keeps offering, fills the pipeline
  initial begin
    wait (accepted >= 650);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  // idle rates per phase: sender 8 / receiver 66, then swapped, then none
  function automatic int send_idle_pct();
    if (accepted < 300) return 8;
    if (accepted < 600) return 66;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (accepted < 300) return 66;
    if (accepted < 600) return 8;
    return 0;
  endfunction

  // transaction acceptance on the input side
  always @(posedge clk) begin
    taken = 1'b0;
    if (rst_n && in_valid && !in_stall) begin
      texel_req_t t;
      t.px = in_point_x;
      t.py = in_point_y;
      t.pz = in_point_z;
      t.amp = in_amplitude;
      t.scl = in_scale;
      t.seed = in_seed;
      factor_q.push_back(predict_factor(t));
      accepted++;
      taken = 1'b1;
    end
  end

  // driver: holds the payload until accepted, then pulls the next texel
  always @(negedge clk) begin
    if (rst_n && (!in_valid || taken)) begin
      if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
        texel_req_t t;
        t = pending_q.pop_front();
        in_valid <= 1'b1;
        in_point_x <= t.px;
        in_point_y <= t.py;
        in_point_z <= t.pz;
        in_amplitude <= t.amp;
        in_scale <= t.scl;
        in_seed <= t.seed;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver backpressure
  always @(negedge clk) begin
    out_stall <= hold_off || ($urandom_range(0, 99) < recv_idle_pct());
  end

  // monitor: each result against the oldest expected factor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (factor_q.size() == 0) begin
        report_mismatch("unexpected result", {8'h0, out_factor}, 32'h0);
      end else begin
        refl_t e;
        e = factor_q.pop_front();
        if (out_factor !== e.factor) report_mismatch("factor", {8'h0, out_factor}, {8'h0, e.factor});
        if (out_saturated !== e.sat) report_mismatch("saturated", {31'h0, out_saturated}, {31'h0, e.sat});
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb_value_noise_texture_factor_core failed");
      $finish;
    end
  end

  // end of run: drain, let the pipeline settle, then decide
  initial begin
    wait (stim_done);
    wait (factor_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (factor_q.size() != 0) report_mismatch("missing results", factor_q.size(), 32'h0);
    if (errors == 0) begin
      $display("tb_value_noise_texture_factor_core passed");
    end else begin
      $display("tb_value_noise_texture_factor_core failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/vntf_pkg.sv
rtl/vntf_div_step.sv
rtl/vntf_octave.sv
rtl/vntf_combine.sv
rtl/value_noise_texture_factor_core.sv
test/tb_value_noise_texture_factor_core.sv
